// ----- hw/rtl/efr_pkg.sv -----
package efr_pkg;

  localparam logic [7:0] ESC_BYTE        = 8'hAA;
  localparam logic [7:0] SOF_BYTE        = 8'h55;
  localparam logic [7:0] LITERAL_AA_BYTE = 8'h01;
  localparam logic [7:0] MAX_LEN_RESET   = 8'd130;

  localparam int FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    TK_DATA,
    TK_SOF,
    TK_BAD_ESC
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  data;
  } token_t;

  typedef enum logic [2:0] {
    EV_PAYLOAD    = 3'd0,
    EV_CRC_GOOD   = 3'd1,
    EV_CRC_BAD    = 3'd2,
    EV_LEN_REJECT = 3'd3,
    EV_ABORT      = 3'd4
  } event_t;

endpackage

// ----- hw/rtl/efr_front.sv -----
module efr_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_line_byte,
  input  logic            q_full,
  output logic            q_push,
  output efr_pkg::token_t q_token
);

  logic esc_r, esc_nxt;
  logic accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    esc_nxt      = esc_r;
    q_push       = 1'b0;
    q_token.kind = efr_pkg::TK_DATA;
    q_token.data = in_line_byte;
    if (accept) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
        q_push  = 1'b1;
        if (in_line_byte == efr_pkg::LITERAL_AA_BYTE) begin
          q_token.data = efr_pkg::ESC_BYTE;
        end else if (in_line_byte == efr_pkg::SOF_BYTE) begin
          q_token.kind = efr_pkg::TK_SOF;
        end else begin
          q_token.kind = efr_pkg::TK_BAD_ESC;
        end
      end else if (in_line_byte == efr_pkg::ESC_BYTE) begin
        esc_nxt = 1'b1;   // swallow escape, wait for partner
      end else begin
        q_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
    end else begin
      esc_r <= esc_nxt;
    end
  end

endmodule

// ----- hw/rtl/efr_fifo.sv -----
module efr_fifo #(
  parameter int WIDTH = 10,
  parameter int DEPTH = efr_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/efr_back.sv -----
module efr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      max_len,
  input  logic            q_valid,
  input  efr_pkg::token_t q_token,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      out_event_res,
  output logic [7:0]      out_payload_byte,
  output logic            out_frame_end
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LENGTH,
    PH_DATA,
    PH_CRC
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [7:0]      remain_r, remain_nxt;
  logic [15:0]     crc_run_r, crc_run_nxt;
  logic [7:0]      crc_lo_r, crc_lo_nxt;
  logic            out_valid_r, out_valid_nxt;
  efr_pkg::event_t out_event_r, out_event_nxt;
  logic [7:0]      out_byte_r, out_byte_nxt;
  logic            out_end_r, out_end_nxt;

  logic            emit;
  efr_pkg::event_t emit_ev;
  logic [7:0]      emit_byte;
  logic [7:0]      b;

  // CRC-16/ARC, reflected poly 0xA001, one byte
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] v;
    v = c ^ {8'h00, d};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ 16'hA001) : (v >> 1);
    end
    return v;
  endfunction

  assign q_pop = q_valid && (!out_valid_r || out_ready);
  assign b     = q_token.data;

  always_comb begin
    phase_nxt   = phase_r;
    remain_nxt  = remain_r;
    crc_run_nxt = crc_run_r;
    crc_lo_nxt  = crc_lo_r;
    emit        = 1'b0;
    emit_ev     = efr_pkg::EV_PAYLOAD;
    emit_byte   = 8'h00;
    if (q_pop) begin
      unique case (q_token.kind)
        efr_pkg::TK_SOF: begin
          emit      = (phase_r != PH_HUNT);
          emit_ev   = efr_pkg::EV_ABORT;
          phase_nxt = PH_LENGTH;
        end
        efr_pkg::TK_BAD_ESC: begin
          emit      = (phase_r != PH_HUNT);
          emit_ev   = efr_pkg::EV_ABORT;
          phase_nxt = PH_HUNT;
        end
        efr_pkg::TK_DATA: begin
          unique case (phase_r)
            PH_HUNT: begin
            end
            PH_LENGTH: begin
              if (b == 8'h00 || b > max_len) begin
                emit      = 1'b1;
                emit_ev   = efr_pkg::EV_LEN_REJECT;
                phase_nxt = PH_HUNT;
              end else begin
                crc_run_nxt = crc_step(16'h0000, b);
                remain_nxt  = b;
                phase_nxt   = PH_DATA;
              end
            end
            PH_DATA: begin
              crc_run_nxt = crc_step(crc_run_r, b);
              emit        = 1'b1;
              emit_byte   = b;
              if (remain_r == 8'd1) begin
                phase_nxt  = PH_CRC;
                remain_nxt = 8'd2;
              end else begin
                remain_nxt = remain_r - 8'd1;
              end
            end
            PH_CRC: begin
              if (remain_r == 8'd2) begin
                crc_lo_nxt = b;
                remain_nxt = 8'd1;
              end else begin
                emit       = 1'b1;
                emit_ev    = ({b, crc_lo_r} == crc_run_r) ? efr_pkg::EV_CRC_GOOD
                                                         : efr_pkg::EV_CRC_BAD;
                remain_nxt = 8'd0;
                phase_nxt  = PH_HUNT;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_event_nxt = out_event_r;
    out_byte_nxt  = out_byte_r;
    out_end_nxt   = out_end_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_event_nxt = emit_ev;
      out_byte_nxt  = emit_byte;
      out_end_nxt   = (emit_ev != efr_pkg::EV_PAYLOAD);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      remain_r    <= 8'd0;
      crc_run_r   <= 16'h0000;
      crc_lo_r    <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      remain_r    <= remain_nxt;
      crc_run_r   <= crc_run_nxt;
      crc_lo_r    <= crc_lo_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_event_r <= out_event_nxt;
    out_byte_r  <= out_byte_nxt;
    out_end_r   <= out_end_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_event_r;
  assign out_payload_byte = out_byte_r;
  assign out_frame_end    = out_end_r;

  a_end_matches_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_end_r == (out_event_r != efr_pkg::EV_PAYLOAD)))
    else $error("frame_end disagrees with event");

  a_byte_zero_on_events: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_r != efr_pkg::EV_PAYLOAD) |-> (out_byte_r == 8'h00))
    else $error("nonzero byte on a frame event");

  a_data_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (remain_r != 8'd0))
    else $error("data phase with no bytes due");

  a_last_payload_to_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_token.kind == efr_pkg::TK_DATA && phase_r == PH_DATA && remain_r == 8'd1)
    |=> (phase_r == PH_CRC && remain_r == 8'd2))
    else $error("last payload beat did not enter CRC phase");

  a_no_pop_into_full_output: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !q_pop)
    else $error("token consumed while result stalled");

endmodule

// ----- hw/rtl/escaped_frame_receiver_crc16.sv -----
// Byte-stuffed frame receiver with CRC-16/ARC check. Each input beat is one
// raw line byte; 0xAA 0x01 decodes to a data 0xAA and 0xAA 0x55 starts a frame.
// A frame is a length byte (1..cfg max, reset 130), that many payload bytes
// and a CRC-16/ARC over length+payload, low byte first. Every payload byte is
// given out as event 0 as it arrives; the frame closes with event 1 (CRC good)
// or 2 (CRC bad). Event 3 reports a rejected length, event 4 an aborted frame
// (bad escape or a new start mark while a frame is open). frame_end marks all
// events but 0. Rate: one input beat per clock while the FIFO has room. The
// front strips escapes in the accept cycle and writes tokens into a small
// FIFO; the back pops one token per cycle unless its output register is
// stalled, runs the byte-wide CRC update and the frame state machine, and
// holds its result in an output register, so input and output stall
// independently. in_ready drops only when the FIFO is full.
// Write cfg_wr_data only while idle.
module escaped_frame_receiver_crc16 #(
  parameter int FIFO_DEPTH = efr_pkg::FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  // config
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  // line byte input
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_line_byte,
  // result output
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_event_res,
  output logic [7:0] out_payload_byte,
  output logic       out_frame_end
);

  localparam int TOK_W = $bits(efr_pkg::token_t);

  logic [7:0]      max_len_r;
  logic            q_push, q_full, q_pop, q_valid;
  efr_pkg::token_t push_tok, pop_tok;
  logic [TOK_W-1:0] pop_bits;

  // max payload length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= efr_pkg::MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // front: escape removal
  efr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_line_byte (in_line_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_token      (push_tok)
  );

  // token queue decouples front and back
  efr_fifo #(
    .WIDTH (TOK_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_tok),
    .full      (q_full),
    .pop       (q_pop),
    .rd_valid  (q_valid),
    .rd_data   (pop_bits)
  );

  assign pop_tok = efr_pkg::token_t'(pop_bits);

  // back: frame parser, CRC, result register
  efr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .max_len          (max_len_r),
    .q_valid          (q_valid),
    .q_token          (pop_tok),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_res    (out_event_res),
    .out_payload_byte (out_payload_byte),
    .out_frame_end    (out_frame_end)
  );

endmodule
